### hw/rtl/cfir_pkg.sv
// Shared constants and types for the complex FIR filter.
// Used by every module under hw/rtl; depends on nothing.
package cfir_pkg;

    localparam int TAPS_DEF        = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COEF_BITS_DEF   = 18;

    // coefficient register file seen by the config port
    localparam int CFG_REGS     = 8;
    localparam int CFG_IDX_BITS = $clog2(CFG_REGS);

    // per-stage load enables of the datapath pipeline
    typedef struct packed {
        logic s1;   // window shift on input beat
        logic s2;   // product register load
        logic s3;   // pair-sum register load
    } t_pipe_en;

endpackage

### hw/rtl/cfir_coef_bank.sv
// Coefficient registers written through the configuration port.
// Depends on cfir_pkg for the register index width.
module cfir_coef_bank #(
    parameter int TAPS      = 8,
    parameter int COEF_BITS = 18
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [cfir_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [COEF_BITS-1:0]               i_cfg_data,
    output logic signed [COEF_BITS-1:0]        o_coef [TAPS]
);
    import cfir_pkg::*;

    // newest tap resets to just under unity, the rest to zero
    localparam logic [COEF_BITS-1:0] COEF0_RST = {1'b0, {(COEF_BITS-1){1'b1}}};

    logic signed [COEF_BITS-1:0] r_coef [TAPS];

    for (genvar k = 0; k < TAPS; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_coef[k] <= (k == 0) ? COEF0_RST : '0;
            end else if (i_cfg_valid && (i_cfg_index == CFG_IDX_BITS'(k))) begin
                r_coef[k] <= i_cfg_data;
            end
        end
        assign o_coef[k] = r_coef[k];
    end

endmodule

### hw/rtl/cfir_chan.sv
// One channel of the filter: sample window, per-tap multipliers, pair adders.
// Depends on cfir_pkg for the stage enable struct.
module cfir_chan #(
    parameter  int TAPS        = 8,
    parameter  int SAMPLE_BITS = 16,
    parameter  int COEF_BITS   = 18,
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS,
    localparam int PAIRS       = (TAPS + 1) / 2,
    localparam int PAIR_W      = PROD_W + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cfir_pkg::t_pipe_en             i_en,
    input  logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  logic signed [COEF_BITS-1:0]    i_coef [TAPS],
    output logic signed [PAIR_W-1:0]       o_pair [PAIRS]
);
    import cfir_pkg::*;

    // r_win[0] is the newest sample; the window doubles as the history
    logic signed [SAMPLE_BITS-1:0] r_win  [TAPS];
    logic signed [PROD_W-1:0]      n_prod [TAPS];
    logic signed [PROD_W-1:0]      r_prod [TAPS];
    logic signed [PAIR_W-1:0]      n_pair [PAIRS];
    logic signed [PAIR_W-1:0]      r_pair [PAIRS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) r_win[k] <= '0;
        end else if (i_en.s1) begin
            r_win[0] <= i_sample;
            for (int k = 1; k < TAPS; k++) r_win[k] <= r_win[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < TAPS; k++) n_prod[k] = i_coef[k] * r_win[k];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int k = 0; k < TAPS; k++) r_prod[k] <= n_prod[k];
        end
    end

    for (genvar j = 0; j < PAIRS; j++) begin : g_pair
        if (2*j + 1 < TAPS) begin : g_two
            assign n_pair[j] = PAIR_W'(r_prod[2*j]) + PAIR_W'(r_prod[2*j+1]);
        end else begin : g_one
            assign n_pair[j] = PAIR_W'(r_prod[2*j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int j = 0; j < PAIRS; j++) r_pair[j] <= n_pair[j];
        end
    end

    assign o_pair = r_pair;

endmodule

### hw/rtl/cfir_round_sat.sv
// Final sum of the pair results, round half up, scale and saturate.
// Depends on cfir_pkg only through the common import style.
module cfir_round_sat #(
    parameter  int TAPS        = 8,
    parameter  int SAMPLE_BITS = 16,
    parameter  int COEF_BITS   = 18,
    localparam int PAIRS       = (TAPS + 1) / 2,
    localparam int PAIR_W      = SAMPLE_BITS + COEF_BITS + 1
) (
    input  logic signed [PAIR_W-1:0]       i_pair [PAIRS],
    output logic signed [SAMPLE_BITS-1:0]  o_value,
    output logic                           o_sat
);
    import cfir_pkg::*;

    localparam int ACC_W = PAIR_W + 2;
    localparam int SH_W  = ACC_W - COEF_BITS + 1;

    localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (COEF_BITS - 2);
    localparam logic signed [SH_W-1:0]  MAXV = SH_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SH_W-1:0]  MINV = -MAXV - SH_W'(1);

    logic signed [ACC_W-1:0] acc;
    logic signed [SH_W-1:0]  scaled;

    always_comb begin
        acc = RND;
        for (int j = 0; j < PAIRS; j++) acc = acc + ACC_W'(i_pair[j]);
        // arithmetic shift floors; the dropped top bits are sign copies
        scaled = SH_W'(acc >>> (COEF_BITS - 1));
        if (scaled > MAXV) begin
            o_value = MAXV[SAMPLE_BITS-1:0];
            o_sat   = 1'b1;
        end else if (scaled < MINV) begin
            o_value = MINV[SAMPLE_BITS-1:0];
            o_sat   = 1'b1;
        end else begin
            o_value = scaled[SAMPLE_BITS-1:0];
            o_sat   = 1'b0;
        end
    end

endmodule

### hw/rtl/complex_fir_filter_top.sv
// Top level of the complex FIR filter: config port, pipeline control, output register.
// Depends on cfir_pkg, cfir_coef_bank, cfir_chan and cfir_round_sat.
//
// Direct-form FIR with TAPS real coefficients (signed Q1.(COEF_BITS-1)) applied to
// I and Q separately. One I/Q pair is taken every cycle; each result passes through the
// window, product, pair-sum and output registers in turn after its input beat, and the
// pipeline keeps accepting while results wait, stalling the input only when all four
// stages hold data and the result is stalled. Each tap has its own multiplier per
// channel, which sets the one-beat-per-cycle rate. Coefficient writes take effect
// immediately and should be made with the pipeline empty; indexes at or above TAPS
// are dropped. Sums round half up, shift right by COEF_BITS-1 and saturate, with
// o_clipped flagging either channel.
module complex_fir_filter_top #(
    parameter int TAPS        = cfir_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = cfir_pkg::COEF_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [SAMPLE_BITS-1:0]             i_sample_i,
    input  logic [SAMPLE_BITS-1:0]             i_sample_q,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [SAMPLE_BITS-1:0]             o_filtered_i,
    output logic [SAMPLE_BITS-1:0]             o_filtered_q,
    output logic                               o_clipped,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cfir_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [COEF_BITS-1:0]               i_cfg_data
);
    import cfir_pkg::*;

    localparam int PAIRS  = (TAPS + 1) / 2;
    localparam int PAIR_W = SAMPLE_BITS + COEF_BITS + 1;

    logic signed [COEF_BITS-1:0]   coef   [TAPS];
    logic signed [PAIR_W-1:0]      pair_i [PAIRS];
    logic signed [PAIR_W-1:0]      pair_q [PAIRS];
    logic signed [SAMPLE_BITS-1:0] sum_i;
    logic signed [SAMPLE_BITS-1:0] sum_q;
    logic                          sat_i;
    logic                          sat_q;

    logic     r_v1, r_v2, r_v3, r_out_valid;
    logic     en_out;
    logic     accept;
    t_pipe_en en;

    logic [SAMPLE_BITS-1:0] r_out_i;
    logic [SAMPLE_BITS-1:0] r_out_q;
    logic                   r_clip;

    assign o_cfg_ready = 1'b1;

    cfir_coef_bank #(
        .TAPS      (TAPS),
        .COEF_BITS (COEF_BITS)
    ) u_coef (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_coef      (coef)
    );

    // a stage loads when it is empty or its contents move on this cycle
    assign en_out = !r_out_valid || !i_stall;
    assign en.s3  = !r_v3 || en_out;
    assign en.s2  = !r_v2 || en.s3;
    assign o_stall = !(!r_v1 || en.s2);
    assign accept = i_valid && !o_stall;
    assign en.s1  = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_stall) r_v1        <= i_valid;
            if (en.s2)    r_v2        <= r_v1;
            if (en.s3)    r_v3        <= r_v2;
            if (en_out)   r_out_valid <= r_v3;
        end
    end

    cfir_chan #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_chan_i (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_sample (i_sample_i),
        .i_coef   (coef),
        .o_pair   (pair_i)
    );

    cfir_chan #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_chan_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_sample (i_sample_q),
        .i_coef   (coef),
        .o_pair   (pair_q)
    );

    cfir_round_sat #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_rs_i (
        .i_pair  (pair_i),
        .o_value (sum_i),
        .o_sat   (sat_i)
    );

    cfir_round_sat #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_rs_q (
        .i_pair  (pair_q),
        .o_value (sum_q),
        .o_sat   (sat_q)
    );

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_i <= sum_i;
            r_out_q <= sum_q;
            r_clip  <= sat_i || sat_q;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_filtered_i = r_out_i;
    assign o_filtered_q = r_out_q;
    assign o_clipped    = r_clip;

    // input is held off only with every stage full and the output blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted beat not captured in first stage");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_v3))
        else $error("result appeared without a beat in the last stage");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !en.s3) |=> r_v3)
        else $error("pair stage lost a beat while held");

endmodule

### sim/complex_fir_filter_checker.sv
`timescale 1ns / 1ps
// Watches the sample, result and coefficient channels of complex_fir_filter_top,
// predicts every filtered beat and compares it field by field. Depends on nothing.
module complex_fir_filter_checker #(
    parameter int NTAPS = 8,
    parameter int SB    = 16,
    parameter int CB    = 18,
    parameter int IDXB  = 3
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_smp_valid,
    input  logic            i_smp_stall,
    input  logic [SB-1:0]   i_smp_i,
    input  logic [SB-1:0]   i_smp_q,
    input  logic            i_res_valid,
    input  logic            i_res_stall,
    input  logic [SB-1:0]   i_res_i,
    input  logic [SB-1:0]   i_res_q,
    input  logic            i_res_clip,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  logic [IDXB-1:0] i_cfg_index,
    input  logic [CB-1:0]   i_cfg_data,
    output int              o_fail_count,
    output int              o_outstanding
);

    typedef struct packed {
        logic [SB-1:0] fi;
        logic [SB-1:0] fq;
        logic          clip;
    } t_filt_beat;

    logic signed [CB-1:0] tap_coef [0:NTAPS-1];
    logic signed [SB-1:0] win_i    [0:NTAPS-1];   // entry 0 is the newest sample
    logic signed [SB-1:0] win_q    [0:NTAPS-1];
    t_filt_beat           due_beats[$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic logic [SB-1:0] fir_channel(input bit on_q, output bit clip);
        longint acc;
        longint top;
        int     k;
        acc = 0;
        top = (longint'(1) <<< (SB - 1)) - 1;
        for (k = 0; k < NTAPS; k++)
            acc += longint'(tap_coef[k]) * (on_q ? longint'(win_q[k]) : longint'(win_i[k]));
        // round half up, then floor shift back to sample scale
        acc = (acc + (longint'(1) <<< (CB - 2))) >>> (CB - 1);
        clip = 1'b0;
        if (acc > top) begin
            clip = 1'b1;
            acc  = top;
        end else if (acc < -top - 1) begin
            clip = 1'b1;
            acc  = -top - 1;
        end
        return acc[SB-1:0];
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_filt_beat want;
        bit         clip_i;
        bit         clip_q;
        int         k;
        if (!i_rst_n) begin
            for (k = 0; k < NTAPS; k++) begin
                tap_coef[k] = '0;
                win_i[k]    = '0;
                win_q[k]    = '0;
            end
            tap_coef[0] = CB'((1 << (CB - 1)) - 1);
            due_beats.delete();
        end else begin
            // retire the result first so a beat never matches one pushed this edge
            if (i_res_valid && !i_res_stall) begin
                if (due_beats.size() == 0) begin
                    $error("result beat with nothing outstanding: i=%0d q=%0d clipped=%0d",
                           $signed(i_res_i), $signed(i_res_q), i_res_clip);
                    o_fail_count++;
                end else begin
                    want = due_beats.pop_front();
                    check_field("filtered_i", $signed(want.fi), $signed(i_res_i));
                    check_field("filtered_q", $signed(want.fq), $signed(i_res_q));
                    check_field("clipped", want.clip, i_res_clip);
                end
            end
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NTAPS)
                tap_coef[i_cfg_index] = i_cfg_data;
            if (i_smp_valid && !i_smp_stall) begin
                for (k = NTAPS - 1; k > 0; k--) begin
                    win_i[k] = win_i[k-1];
                    win_q[k] = win_q[k-1];
                end
                win_i[0]  = i_smp_i;
                win_q[0]  = i_smp_q;
                want.fi   = fir_channel(1'b0, clip_i);
                want.fq   = fir_channel(1'b1, clip_q);
                want.clip = clip_i | clip_q;
                due_beats.push_back(want);
            end
        end
        o_outstanding = due_beats.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for complex_fir_filter_top: coefficient loads, sample streams
// under varying idle and stall mixes. Depends on cfir_pkg and complex_fir_filter_checker.
module tb;
    import cfir_pkg::*;

    localparam int NTAPS     = TAPS_DEF;
    localparam int SB        = SAMPLE_BITS_DEF;
    localparam int CB        = COEF_BITS_DEF;
    localparam int RUN_LIMIT = 100000;
    localparam int ROUNDS    = 6;
    localparam int ROUND_LEN = 242;

    typedef enum int {
        TAPS_WIDE,
        TAPS_NARROW,
        TAPS_SPARSE,
        TAPS_TOP,
        TAPS_BOTTOM
    } t_tap_mix;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic [SB-1:0]           i_sample_i  = '0;
    logic [SB-1:0]           i_sample_q  = '0;
    logic                    i_stall     = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CB-1:0]           i_cfg_data  = '0;
    logic                    o_stall;
    logic                    o_valid;
    logic [SB-1:0]           o_filtered_i;
    logic [SB-1:0]           o_filtered_q;
    logic                    o_clipped;
    logic                    o_cfg_ready;

    int            fail_count;
    int            outstanding;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_left      = 0;
    int            send_pcts [4]  = '{0, 61, 0, 17};
    int            recv_pcts [4]  = '{0, 0, 61, 17};
    logic [CB-1:0] tap_set [0:NTAPS-1];

    complex_fir_filter_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample_i   (i_sample_i),
        .i_sample_q   (i_sample_q),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_filtered_i (o_filtered_i),
        .o_filtered_q (o_filtered_q),
        .o_clipped    (o_clipped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    complex_fir_filter_checker #(
        .NTAPS (NTAPS),
        .SB    (SB),
        .CB    (CB),
        .IDXB  (CFG_IDX_BITS)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_smp_valid   (i_valid),
        .i_smp_stall   (o_stall),
        .i_smp_i       (i_sample_i),
        .i_smp_q       (i_sample_q),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_res_i       (o_filtered_i),
        .i_res_q       (o_filtered_q),
        .i_res_clip    (o_clipped),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: a long hold-off when requested, random stalls otherwise
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(SB-1){1'b1}}};
            1:       return {1'b1, {(SB-1){1'b0}}};
            2:       return '0;
            3:       return SB'($urandom_range(511) - 256);
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [CB-1:0] pick_coef(input t_tap_mix mix);
        case (mix)
            TAPS_NARROW: return CB'($urandom_range(8191) - 4096);
            TAPS_SPARSE: return ($urandom_range(3) == 0) ? CB'($urandom) : '0;
            TAPS_TOP:    return {1'b0, {(CB-1){1'b1}}};
            TAPS_BOTTOM: return {1'b1, {(CB-1){1'b0}}};
            default:     return CB'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic [SB-1:0] si, input logic [SB-1:0] sq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_sample_i <= si;
        i_sample_q <= sq;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // wait for the pipeline to empty before touching coefficients
    task automatic settle();
        i_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic load_taps();
        int k;
        for (k = 0; k < NTAPS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_BITS'(k);
            i_cfg_data  <= tap_set[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic fill_taps(input t_tap_mix mix);
        int k;
        for (k = 0; k < NTAPS; k++)
            tap_set[k] = pick_coef(mix);
        load_taps();
    endtask

    initial begin : stim
        t_tap_mix mixes [ROUNDS];
        int       r;
        int       n;
        mixes = '{TAPS_WIDE, TAPS_NARROW, TAPS_SPARSE, TAPS_TOP, TAPS_NARROW, TAPS_BOTTOM};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset taps: near-unity gain on the newest sample
        send_beat(16'h0000, 16'h0000);
        send_beat(16'h7fff, 16'h8000);
        send_beat(16'h8000, 16'h7fff);
        send_beat(16'h0001, 16'hffff);
        send_beat(16'hffff, 16'h0001);
        settle();

        // half gain: rounding ties on odd samples
        for (n = 0; n < NTAPS; n++)
            tap_set[n] = '0;
        tap_set[0] = CB'(1 << (CB - 2));
        load_taps();
        send_beat(16'h0001, 16'hffff);
        send_beat(16'h0003, 16'hfffd);
        send_beat(16'hfffd, 16'h0003);
        settle();

        // full-scale taps: drive both rails into saturation
        fill_taps(TAPS_TOP);
        for (n = 0; n < NTAPS; n++)
            send_beat(16'h7fff, 16'h8000);
        send_beat(16'h0000, 16'h0000);
        settle();
        fill_taps(TAPS_BOTTOM);
        for (n = 0; n < 4; n++)
            send_beat(16'h8000, 16'h7fff);
        settle();

        for (r = 0; r < ROUNDS; r++) begin
            send_idle_pct  = send_pcts[r % 4];
            recv_stall_pct = recv_pcts[r % 4];
            fill_taps(mixes[r]);
            if (r == 0)
                hold_left = 400;
            for (n = 0; n < ROUND_LEN; n++)
                send_beat(pick_sample(), ($urandom_range(7) == 0) ? '0 : pick_sample());
            settle();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
